/* design/pnm_hs_pkg.sv */
// shared types and constants for the pnm header strip stream core
// no dependencies; imported by the parser, the result buffer and the top level
package pnm_hs_pkg;

    // result status codes
    localparam logic [2:0] ST_HEADER   = 3'd0;
    localparam logic [2:0] ST_PAYLOAD  = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_UNRECOG  = 3'd3;
    localparam logic [2:0] ST_UNSUPP   = 3'd4;
    localparam logic [2:0] ST_SHORT    = 3'd5;

    // samples per pixel codes
    localparam logic [1:0] SPP_NONE  = 2'd0;
    localparam logic [1:0] SPP_GRAY  = 2'd1;
    localparam logic [1:0] SPP_COLOR = 2'd3;

    // header characters
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_5    = 8'h35;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    // maxval above this uses two bytes per sample
    localparam int WORD_THRESH = 255;

    // packed output word width
    localparam int TDATA_W = 64;

    // one result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic [2:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic [1:0]  samples_per_pixel;
    } res_t;

endpackage

/* design/pnm_hs_parse.sv */
// header parser and payload counter: one byte in, one result out per step
// depends on pnm_hs_pkg
module pnm_hs_parse #(
    parameter int DIM_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              is_last,
    output pnm_hs_pkg::res_t  res
);
    import pnm_hs_pkg::*;

    localparam int ACC_W = (DIM_BITS > 16) ? DIM_BITS : 16;
    localparam int NXT_W = ACC_W + 4;
    localparam int ROW_W = DIM_BITS + 3;

    localparam logic [NXT_W-1:0] DIM_MAX_X = {{(NXT_W-DIM_BITS){1'b0}}, {DIM_BITS{1'b1}}};
    localparam logic [NXT_W-1:0] MAXV_X    = {{(NXT_W-16){1'b0}}, 16'hFFFF};
    localparam logic [ACC_W-1:0] WORD_LIM  = ACC_W'(WORD_THRESH);

    // parse phases
    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_FORMAT  = 3'd1;
    localparam logic [2:0] PH_WIDTH   = 3'd2;
    localparam logic [2:0] PH_HEIGHT  = 3'd3;
    localparam logic [2:0] PH_MAXVAL  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    // gap modes
    localparam logic [1:0] GAP_SKIP    = 2'd0;
    localparam logic [1:0] GAP_COMMENT = 2'd1;
    localparam logic [1:0] GAP_AFTER   = 2'd2;
    localparam logic [1:0] GAP_DIGITS  = 2'd3;

    logic [2:0]          phase_reg, phase_next;
    logic [1:0]          gap_reg, gap_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [15:0]         maxval_reg, maxval_next;
    logic [1:0]          spp_reg, spp_next;
    logic [ROW_W-1:0]    row_left_reg, row_left_next;
    logic [ROW_W-1:0]    row_len_reg, row_len_next;
    logic [DIM_BITS-1:0] rows_left_reg, rows_left_next;
    logic [2:0]          err_reg, err_next;

    logic             is_sp;
    logic             is_dig;
    logic             tok;
    logic [1:0]       gap_tok;
    logic [NXT_W-1:0] acc_x;
    logic [NXT_W-1:0] acc_ten;
    logic [NXT_W-1:0] limit;
    logic [ROW_W-1:0] w_x;
    logic [ROW_W-1:0] w_spp;
    logic [ROW_W-1:0] len;
    logic             valid;
    logic [2:0]       status;
    logic [DIM_BITS+15:0] w_ext;
    logic [DIM_BITS+15:0] h_ext;

    // byte classes
    assign is_sp  = data_byte inside {CH_SP, CH_TAB, CH_NL};
    assign is_dig = data_byte inside {[CH_0:CH_9]};

    // whitespace and single comment skipping
    always_comb
    begin
        tok     = 1'b0;
        gap_tok = gap_reg;
        if (gap_reg == GAP_COMMENT)
        begin
            if (data_byte == CH_NL)
                gap_tok = GAP_AFTER;
        end
        else if (is_sp)
            tok = 1'b0;
        else if (gap_reg == GAP_SKIP && data_byte == CH_HASH)
            gap_tok = GAP_COMMENT;
        else
            tok = 1'b1;
    end

    // decimal accumulate and row length
    assign acc_x   = {4'b0, acc_reg};
    assign acc_ten = (acc_x << 3) + (acc_x << 1) + {{(NXT_W-4){1'b0}}, data_byte[3:0]};
    assign limit   = (phase_reg == PH_MAXVAL) ? MAXV_X : DIM_MAX_X;
    assign w_x     = {3'b0, width_reg};
    assign w_spp   = (spp_reg == SPP_GRAY) ? w_x : (w_x + (w_x << 1));
    assign len     = (acc_reg > WORD_LIM) ? (w_spp << 1) : w_spp;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        gap_next       = gap_reg;
        acc_next       = acc_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        maxval_next    = maxval_reg;
        spp_next       = spp_reg;
        row_left_next  = row_left_reg;
        row_len_next   = row_len_reg;
        rows_left_next = rows_left_reg;
        err_next       = err_reg;
        valid          = 1'b0;
        case (phase_reg)
            PH_MAGIC:
            begin
                gap_next = gap_tok;
                if (tok)
                begin
                    if (data_byte == CH_P)
                    begin
                        phase_next = PH_FORMAT;
                        gap_next   = GAP_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        err_next   = ST_UNRECOG;
                    end
                end
            end
            PH_FORMAT:
            begin
                if (data_byte inside {CH_5, CH_6})
                begin
                    spp_next   = (data_byte == CH_5) ? SPP_GRAY : SPP_COLOR;
                    phase_next = PH_WIDTH;
                    gap_next   = GAP_SKIP;
                    acc_next   = '0;
                end
                else if (data_byte inside {[CH_1:CH_4]})
                begin
                    phase_next = PH_DONE;
                    err_next   = ST_UNSUPP;
                end
                else
                begin
                    phase_next = PH_DONE;
                    err_next   = ST_UNRECOG;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                if (gap_reg != GAP_DIGITS)
                begin
                    gap_next = gap_tok;
                    if (tok)
                    begin
                        if (!is_dig)
                        begin
                            phase_next = PH_DONE;
                            err_next   = ST_UNRECOG;
                        end
                        else
                        begin
                            acc_next = {{(ACC_W-4){1'b0}}, data_byte[3:0]};
                            gap_next = GAP_DIGITS;
                        end
                    end
                end
                else if (is_dig)
                begin
                    if (acc_ten > limit)
                    begin
                        phase_next = PH_DONE;
                        err_next   = ST_UNRECOG;
                    end
                    else
                        acc_next = acc_ten[ACC_W-1:0];
                end
                else
                begin
                    // terminator byte closes the number
                    acc_next = '0;
                    gap_next = GAP_SKIP;
                    if (phase_reg == PH_WIDTH)
                    begin
                        width_next = acc_reg[DIM_BITS-1:0];
                        phase_next = PH_HEIGHT;
                    end
                    else if (phase_reg == PH_HEIGHT)
                    begin
                        height_next = acc_reg[DIM_BITS-1:0];
                        phase_next  = PH_MAXVAL;
                    end
                    else
                    begin
                        maxval_next = acc_reg[15:0];
                        if (len == '0 || height_reg == '0)
                        begin
                            phase_next = PH_DONE;
                            err_next   = ST_COMPLETE;
                        end
                        else
                        begin
                            rows_left_next = height_reg;
                            row_left_next  = len;
                            row_len_next   = len;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                valid = 1'b1;
                if (row_left_reg != '0)
                    row_left_next = row_left_reg - ROW_W'(1);
                if (row_left_next == '0)
                begin
                    if (rows_left_reg != '0)
                        rows_left_next = rows_left_reg - DIM_BITS'(1);
                    if (rows_left_next == '0)
                    begin
                        phase_next = PH_DONE;
                        err_next   = ST_COMPLETE;
                    end
                    else
                        row_left_next = row_len_reg;
                end
            end
            default:
            begin
                valid = 1'b0;
            end
        endcase

        // end of input before finish
        if (is_last && phase_next != PH_DONE)
        begin
            err_next   = (phase_next == PH_PAYLOAD) ? ST_SHORT : ST_UNRECOG;
            phase_next = PH_DONE;
        end
    end

    // result of this byte
    always_comb
    begin
        if (phase_next == PH_DONE)
            status = err_next;
        else if (phase_next == PH_PAYLOAD)
            status = ST_PAYLOAD;
        else
            status = ST_HEADER;
    end

    assign w_ext = {16'b0, width_next};
    assign h_ext = {16'b0, height_next};

    assign res.out_byte          = valid ? data_byte : 8'd0;
    assign res.out_valid         = valid;
    assign res.status            = status;
    assign res.image_width       = w_ext[15:0];
    assign res.image_height      = h_ext[15:0];
    assign res.max_value         = maxval_next;
    assign res.samples_per_pixel = spp_next;

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            gap_reg       <= GAP_SKIP;
            acc_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            maxval_reg    <= '0;
            spp_reg       <= SPP_NONE;
            row_left_reg  <= '0;
            row_len_reg   <= '0;
            rows_left_reg <= '0;
            err_reg       <= ST_HEADER;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            gap_reg       <= gap_next;
            acc_reg       <= acc_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            maxval_reg    <= maxval_next;
            spp_reg       <= spp_next;
            row_left_reg  <= row_left_next;
            row_len_reg   <= row_len_next;
            rows_left_reg <= rows_left_next;
            err_reg       <= err_next;
        end
    end

    // forwarded bytes only come out of the payload phase
    a_valid_payload: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.out_valid |-> phase_reg == PH_PAYLOAD)
        else $error("payload byte forwarded outside payload phase");

    // finished stays finished
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE && $stable(err_reg))
        else $error("finished parser left done state");

    // payload counters never idle at zero
    a_payload_counts: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> row_left_reg != '0 && rows_left_reg != '0)
        else $error("payload phase with empty counters");

    // finish code is always a final status
    a_final_code: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_next == PH_DONE |-> err_next >= ST_COMPLETE && err_next <= ST_SHORT)
        else $error("finish with a non-final status");

endmodule

/* design/pnm_hs_res_buf.sv */
// two-entry result buffer between the parser and the output stream
// depends on pnm_hs_pkg
module pnm_hs_res_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pnm_hs_pkg::res_t  push_res,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output pnm_hs_pkg::res_t  out_res
);
    import pnm_hs_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_res;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // no request written into a full buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result buffer overflow");

    // fill count agrees with the pointers
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("result buffer pointers out of step");

endmodule

/* design/pnm_header_strip_stream_core.sv */
// top level of the pnm header strip stream core: input register, parser, result buffer
// depends on pnm_hs_pkg, pnm_hs_parse and pnm_hs_res_buf

// Parses a binary PGM (P5) or PPM (P6) byte stream and passes the image payload
// through. Every input byte yields exactly one result request carrying the
// forwarded byte (m_tuser high when it is payload), the running status and the
// parsed header fields. One byte is taken per clock while the result buffer has
// room. A byte is held in the input register while the single-pass parser writes
// its result into the two-entry result buffer, which presents it on the output;
// the byte passes the input register and then a buffer entry before it can be
// taken. The input side stalls only when that buffer is full. After complete
// or an error the block keeps answering with the final status until reset.
// DIM_BITS sets the largest accepted width and height (2^DIM_BITS-1); the
// reported image_width and image_height are the low 16 bits of those values.
module pnm_header_strip_stream_core #(
    parameter int DIM_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: data_byte[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // m_tdata: out_byte[7:0], status[10:8], image_width[26:11],
    // image_height[42:27], max_value[58:43], samples_per_pixel[60:59], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [pnm_hs_pkg::TDATA_W-1:0] m_tdata,
    // m_tuser: out_valid
    output logic        m_tuser
);
    import pnm_hs_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       step;
    logic       can_push;
    res_t       step_res;
    res_t       out_res;

    assign step     = in_vld_reg && can_push;
    assign s_tready = !in_vld_reg || can_push;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pnm_hs_parse #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .res       (step_res)
    );

    pnm_hs_res_buf u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_res  (step_res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // output packing
    assign m_tdata = {3'b0,
                      out_res.samples_per_pixel,
                      out_res.max_value,
                      out_res.image_height,
                      out_res.image_width,
                      out_res.status,
                      out_res.out_byte};
    assign m_tuser = out_res.out_valid;

endmodule

/* tb/tb.sv */
// self-checking testbench for pnm_header_strip_stream_core: one pgm/ppm stream per run,
// fixed header rows then random payload with a random ending, checked against a predictor
// depends on pnm_hs_pkg and the design sources under design/
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pnm_hs_pkg::*;

    localparam int DIM_BITS = 16;
    localparam int unsigned DIM_LIMIT = (32'd1 << DIM_BITS) - 1;
    localparam int unsigned MAXVAL_LIMIT = 65535;
    // header below declares 20 x 8 color pixels with two-byte samples
    localparam int PAYLOAD_BYTES = 20 * 8 * 3 * 2;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_AT = 400;
    localparam int ITEMS = 1050;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_FORMAT, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PAYLOAD, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        GAP_WS, GAP_COMMENT, GAP_WS_AFTER, GAP_DIGITS
    } gap_t;

    // one line of the header table; typed rows carry their own expectation
    typedef struct {
        string text;
        bit    typed;
        res_t  want;
    } hdr_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'h00;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;

    // predicted parser state
    phase_t      hdr_phase;
    gap_t        hdr_gap;
    int unsigned num_acc;
    int unsigned width_q;
    int unsigned height_q;
    logic [15:0] maxval_q;
    logic [1:0]  spp_q;
    int unsigned row_left;
    int unsigned rows_left_q;
    logic [2:0]  final_status;

    res_t     pending_results[$];
    hdr_row_t hdr_rows[$];
    int       bytes_taken = 0;
    int       results_taken = 0;
    int       fail_count = 0;

    pnm_header_strip_stream_core #(
        .DIM_BITS(DIM_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic int unsigned row_bytes();
        return width_q * ((maxval_q > WORD_THRESH) ? 2 : 1) * spp_q;
    endfunction

    function automatic void finish_with(logic [2:0] code);
        hdr_phase = PH_DONE;
        final_status = code;
    endfunction

    // whitespace and at most one comment; returns 1 when c is a token byte
    function automatic bit gap_token(logic [7:0] c);
        if (hdr_gap == GAP_COMMENT)
        begin
            if (c == CH_NL)
                hdr_gap = GAP_WS_AFTER;
            return 1'b0;
        end
        if (c inside {CH_SP, CH_TAB, CH_NL})
            return 1'b0;
        if (hdr_gap == GAP_WS && c == CH_HASH)
        begin
            hdr_gap = GAP_COMMENT;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the predicted parser by one byte and form its result
    task automatic strip_byte(input logic [7:0] c, input logic last, output res_t r);
        bit          fwd;
        int unsigned lim;
        int unsigned nxt;
        fwd = 1'b0;
        case (hdr_phase)
            PH_MAGIC:
            begin
                if (gap_token(c))
                begin
                    if (c == CH_P)
                    begin
                        hdr_phase = PH_FORMAT;
                        hdr_gap = GAP_WS;
                    end
                    else
                        finish_with(ST_UNRECOG);
                end
            end
            PH_FORMAT:
            begin
                if (c inside {CH_5, CH_6})
                begin
                    spp_q = (c == CH_5) ? SPP_GRAY : SPP_COLOR;
                    hdr_phase = PH_WIDTH;
                    hdr_gap = GAP_WS;
                    num_acc = 0;
                end
                else if (c inside {[CH_1:CH_4]})
                    finish_with(ST_UNSUPP);
                else
                    finish_with(ST_UNRECOG);
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                lim = (hdr_phase == PH_MAXVAL) ? MAXVAL_LIMIT : DIM_LIMIT;
                if (hdr_gap != GAP_DIGITS)
                begin
                    if (gap_token(c))
                    begin
                        if (!(c inside {[CH_0:CH_9]}))
                            finish_with(ST_UNRECOG);
                        else
                        begin
                            num_acc = c - CH_0;
                            hdr_gap = GAP_DIGITS;
                        end
                    end
                end
                else if (c inside {[CH_0:CH_9]})
                begin
                    nxt = num_acc * 10 + (c - CH_0);
                    if (nxt > lim)
                        finish_with(ST_UNRECOG);
                    else
                        num_acc = nxt;
                end
                else
                begin
                    // terminator byte closes the number
                    hdr_gap = GAP_WS;
                    case (hdr_phase)
                        PH_WIDTH:
                        begin
                            width_q = num_acc;
                            hdr_phase = PH_HEIGHT;
                        end
                        PH_HEIGHT:
                        begin
                            height_q = num_acc;
                            hdr_phase = PH_MAXVAL;
                        end
                        default:
                        begin
                            maxval_q = num_acc[15:0];
                            if (row_bytes() == 0 || height_q == 0)
                                finish_with(ST_COMPLETE);
                            else
                            begin
                                rows_left_q = height_q;
                                row_left = row_bytes();
                                hdr_phase = PH_PAYLOAD;
                            end
                        end
                    endcase
                    num_acc = 0;
                end
            end
            PH_PAYLOAD:
            begin
                fwd = 1'b1;
                if (row_left > 0)
                    row_left--;
                if (row_left == 0)
                begin
                    if (rows_left_q > 0)
                        rows_left_q--;
                    if (rows_left_q == 0)
                        finish_with(ST_COMPLETE);
                    else
                        row_left = row_bytes();
                end
            end
            default: ;
        endcase

        // end of input closes the stream
        if (last && hdr_phase != PH_DONE)
            finish_with(hdr_phase == PH_PAYLOAD ? ST_SHORT : ST_UNRECOG);

        r.out_byte = fwd ? c : 8'h00;
        r.out_valid = fwd;
        if (hdr_phase == PH_DONE)
            r.status = final_status;
        else if (hdr_phase == PH_PAYLOAD)
            r.status = ST_PAYLOAD;
        else
            r.status = ST_HEADER;
        r.image_width = width_q[15:0];
        r.image_height = height_q[15:0];
        r.max_value = maxval_q;
        r.samples_per_pixel = spp_q;
    endtask

    // offer one byte, log its expectation on acceptance, then maybe idle
    task automatic offer_byte(input logic [7:0] c, input logic last, input bit typed,
                              input res_t want);
        res_t model_res;
        int   gap;
        s_tdata <= c;
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        strip_byte(c, last, model_res);
        pending_results.push_back(typed ? want : model_res);
        bytes_taken++;
        gap = 0;
        if (((bytes_taken / 100) % 4) != 3)
        begin
            case ($urandom_range(0, 19))
                0: gap = $urandom_range(8, 25);
                1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        res_t want;
        res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_taken++;
            got.out_byte = m_tdata[7:0];
            got.out_valid = m_tuser;
            got.status = m_tdata[10:8];
            got.image_width = m_tdata[26:11];
            got.image_height = m_tdata[42:27];
            got.max_value = m_tdata[58:43];
            got.samples_per_pixel = m_tdata[60:59];
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result byte=%02h valid=%0b status=%0d",
                                       got.out_byte, got.out_valid, got.status));
            else
            begin
                want = pending_results.pop_front();
                if (got.out_byte != want.out_byte || got.out_valid != want.out_valid ||
                    got.status != want.status || got.image_width != want.image_width ||
                    got.image_height != want.image_height ||
                    got.max_value != want.max_value ||
                    got.samples_per_pixel != want.samples_per_pixel)
                    note_failure($sformatf(
                        "exp byte=%02h v=%0b st=%0d w=%0d h=%0d max=%0d spp=%0d / got byte=%02h v=%0b st=%0d w=%0d h=%0d max=%0d spp=%0d",
                        want.out_byte, want.out_valid, want.status, want.image_width,
                        want.image_height, want.max_value, want.samples_per_pixel,
                        got.out_byte, got.out_valid, got.status, got.image_width,
                        got.image_height, got.max_value, got.samples_per_pixel));
            end
        end
    end

    // result side: random stalls, calm stretches and one long hold-off
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int cycles;
        bit held;
        stall_left = 0;
        hold_left = 0;
        cycles = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycles++;
            if (!held && results_taken >= 120)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (((cycles / 200) % 3) != 2 && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
                                                               : $urandom_range(1, 3);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        res_t        blank;
        res_t        hdr_p6;
        res_t        hdr_done;
        hdr_row_t    row;
        int          ending;
        int          short_at;
        logic [7:0]  c;
        logic        last;

        hdr_phase = PH_MAGIC;
        hdr_gap = GAP_WS;
        num_acc = 0;
        width_q = 0;
        height_q = 0;
        maxval_q = 16'd0;
        spp_q = SPP_NONE;
        row_left = 0;
        rows_left_q = 0;
        final_status = ST_HEADER;

        blank = '{8'h00, 1'b0, ST_HEADER, 16'd0, 16'd0, 16'd0, SPP_NONE};
        hdr_p6 = '{8'h00, 1'b0, ST_HEADER, 16'd0, 16'd0, 16'd0, SPP_COLOR};
        hdr_done = '{8'h00, 1'b0, ST_PAYLOAD, 16'd20, 16'd8, 16'd65535, SPP_COLOR};

        // whitespace and a comment before the magic, a comment before the width,
        // leading zero, tab and letter terminators, maxval at its limit
        hdr_rows.push_back('{text: " #c\n\t", typed: 1'b1, want: blank});
        hdr_rows.push_back('{text: "P", typed: 1'b1, want: blank});
        hdr_rows.push_back('{text: "6", typed: 1'b1, want: hdr_p6});
        hdr_rows.push_back('{text: "#d\n020 8\t65535", typed: 1'b0, want: blank});
        hdr_rows.push_back('{text: "x", typed: 1'b1, want: hdr_done});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header table
        foreach (hdr_rows[r])
        begin
            row = hdr_rows[r];
            for (int i = 0; i < row.text.len(); i++)
                offer_byte(row.text[i], 1'b0, row.typed, row.want);
        end

        // payload with a random ending: exact end marked, exact end unmarked, or cut short
        ending = $urandom_range(0, 9);
        short_at = (ending >= 8) ? $urandom_range(DRAIN_AT + 1, PAYLOAD_BYTES - 2)
                                 : PAYLOAD_BYTES;
        for (int i = 0; i < PAYLOAD_BYTES && i <= short_at; i++)
        begin
            if (i == DRAIN_AT)
            begin
                // sender pauses until the block has drained
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (i == 0)
                c = 8'h00;
            else if (i == 1)
                c = 8'hFF;
            else
                c = 8'($urandom_range(0, 255));
            last = (i == short_at) || (ending <= 5 && i == PAYLOAD_BYTES - 1);
            offer_byte(c, last, 1'b0, blank);
        end

        // bytes after the end only repeat the final status
        while (bytes_taken < ITEMS)
            offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, blank);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
design/pnm_hs_pkg.sv
design/pnm_hs_parse.sv
design/pnm_hs_res_buf.sv
design/pnm_header_strip_stream_core.sv
tb/tb.sv
